>>> rtl/htfd_pkg.sv
// Shared types and constants for the humidity/temperature frame decoder.
// Used by htfd_front, htfd_queue, htfd_back and the top level; no dependencies.
package htfd_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CRC  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  // One classified frame, passed from the front to the back.
  typedef struct packed {
    logic [15:0] raw;
    logic        kind;
    status_e     status;
  } frame_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> rtl/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature frame decoder: front, frame queue and back.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   frame_byte_i, is_humidity_i
//   out      output     out_valid_o / out_stall_i measured_value_o, quantity_kind_o,
//                                                 frame_status_o
//
// One byte is taken per cycle while the frame queue is not full; every third byte
// closes a frame and yields one result, which passes the queue, the operand register and
// the output register, with the single 16x15 multiply in front of the output register.
// Reset clears the frame position, CRC and all valid flags; no clearing pass.
// in_stall_o rises only while the frame queue is full; out_stall_i holds the
// output register and backs up into the queue.
module humidity_temp_frame_decoder #(
  parameter int unsigned QueueDepth = htfd_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         frame_byte_i,
  input  logic               is_humidity_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] measured_value_o,
  output logic               quantity_kind_o,
  output logic [1:0]         frame_status_o
);

  htfd_pkg::queue_stat_t q_stat;
  htfd_pkg::frame_t      push_data;
  htfd_pkg::frame_t      pop_data;
  logic                  push;
  logic                  pop;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .frame_byte_i  (frame_byte_i),
    .is_humidity_i (is_humidity_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  htfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  htfd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_stat_i         (q_stat),
    .pop_data_i       (pop_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .measured_value_o (measured_value_o),
    .quantity_kind_o  (quantity_kind_o),
    .frame_status_o   (frame_status_o)
  );

endmodule

>>> rtl/htfd_front.sv
// Front part: accepts bytes, tracks frame position, runs the CRC-8 and classifies frames.
// Depends on htfd_pkg; pushes one htfd_pkg::frame_t per completed frame.
module htfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           frame_byte_i,
  input  logic                 is_humidity_i,
  input  htfd_pkg::queue_stat_t q_stat_i,
  output logic                 push_o,
  output htfd_pkg::frame_t     push_data_o
);

  typedef enum logic [2:0] {
    POS_HIGH  = 3'b001,
    POS_LOW   = 3'b010,
    POS_CHECK = 3'b100
  } pos_e;

  localparam logic [7:0] CrcPoly = 8'h31;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  pos_e       pos_q, pos_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;
  logic [7:0] crc_q, crc_d;
  logic       kind_q, kind_d;
  logic       accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    pos_d       = pos_q;
    high_d      = high_q;
    low_d       = low_q;
    crc_d       = crc_q;
    kind_d      = kind_q;
    push_o      = 1'b0;
    push_data_o = '{raw: {high_q, low_q}, kind: kind_q, status: htfd_pkg::ST_OK};
    if (accept) begin
      unique case (pos_q)
        POS_LOW: begin
          low_d = frame_byte_i;
          crc_d = crc8_byte(crc_q, frame_byte_i);
          pos_d = POS_CHECK;
        end
        POS_CHECK: begin
          push_o = 1'b1;
          if (high_q == 8'd0 && low_q == 8'd0 && frame_byte_i == 8'd0) begin
            push_data_o.status = htfd_pkg::ST_ZERO;
          end else if (crc_q != frame_byte_i) begin
            push_data_o.status = htfd_pkg::ST_CRC;
          end
          crc_d = 8'd0;
          pos_d = POS_HIGH;
        end
        default: begin
          // high byte, or an unreachable code: start a new frame
          high_d = frame_byte_i;
          kind_d = is_humidity_i;
          crc_d  = crc8_byte(8'd0, frame_byte_i);
          pos_d  = POS_LOW;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_HIGH;
      high_q <= 8'd0;
      low_q  <= 8'd0;
      crc_q  <= 8'd0;
      kind_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      high_q <= high_d;
      low_q  <= low_d;
      crc_q  <= crc_d;
      kind_q <= kind_d;
    end
  end

endmodule

>>> rtl/htfd_queue.sv
// Short FIFO of classified frames between the front and the back.
// Depends on htfd_pkg for the frame and status types.
module htfd_queue #(
  parameter int unsigned Depth = htfd_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  htfd_pkg::frame_t      push_data_i,
  input  logic                  pop_i,
  output htfd_pkg::frame_t      pop_data_o,
  output htfd_pkg::queue_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  htfd_pkg::frame_t entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");

endmodule

>>> rtl/htfd_back.sv
// Back part: masks and scales each frame to hundredths and holds the result for output.
// Depends on htfd_pkg; two stages: operand register, then output register.
module htfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htfd_pkg::queue_stat_t q_stat_i,
  input  htfd_pkg::frame_t  pop_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [14:0] measured_value_o,
  output logic              quantity_kind_o,
  output logic [1:0]        frame_status_o
);

  localparam logic [15:0]        TMask    = 16'hfffc;
  localparam logic [15:0]        RhMask   = 16'hfff0;
  localparam logic [14:0]        TScale   = 15'd17572;
  localparam logic [14:0]        RhScale  = 15'd12500;
  localparam logic signed [15:0] TOffset  = -16'sd4685;
  localparam logic signed [15:0] RhOffset = -16'sd600;

  logic             s1_valid_q;
  htfd_pkg::frame_t s1_q;
  logic             out_valid_q;
  logic signed [14:0] value_q;
  logic             kind_q;
  htfd_pkg::status_e status_q;

  logic             out_ready;
  logic             s1_ready;
  logic [15:0]      masked;
  logic [14:0]      scale;
  logic [30:0]      prod;
  logic signed [15:0] offset;
  logic signed [15:0] value_full;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign pop_o     = !q_stat_i.empty && s1_ready;

  always_comb begin
    masked     = s1_q.raw & (s1_q.kind ? RhMask : TMask);
    scale      = s1_q.kind ? RhScale : TScale;
    offset     = s1_q.kind ? RhOffset : TOffset;
    prod       = 31'(masked * scale);
    value_full = offset + $signed({1'b0, prod[30:16]});
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= pop_data_i;
    end
    if (s1_valid_q && out_ready) begin
      // error frames carry value zero
      value_q  <= (s1_q.status == htfd_pkg::ST_OK) ? value_full[14:0] : 15'sd0;
      kind_q   <= s1_q.kind;
      status_q <= s1_q.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= pop_o;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign measured_value_o = value_q;
  assign quantity_kind_o  = kind_q;
  assign frame_status_o   = status_q;

  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != htfd_pkg::ST_OK) |-> (value_q == 15'sd0))
    else $error("error frame with nonzero value");

endmodule
